// File: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CAS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CAS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: src/cas_pkg.sv
`timescale 1ns / 1ps

package cas_pkg;

	localparam int MAX_CELLS_X_DEF = 14;
	localparam int MAX_CELLS_Y_DEF = 14;
	localparam int MAX_CELLS_Z_DEF = 14;

	localparam int DATA_W = 32;
	localparam int CELL_W = 4;
	localparam int IDX_W  = 3;

	localparam logic signed [DATA_W-1:0] SCALE_RESET = 32'sd65536;
	localparam logic [CELL_W-1:0]        CELLS_RESET = 4'd14;

	localparam logic [IDX_W-1:0] REG_SCALE_X = 3'd0;
	localparam logic [IDX_W-1:0] REG_SCALE_Y = 3'd1;
	localparam logic [IDX_W-1:0] REG_SCALE_Z = 3'd2;
	localparam logic [IDX_W-1:0] REG_CELLS_X = 3'd3;
	localparam logic [IDX_W-1:0] REG_CELLS_Y = 3'd4;
	localparam logic [IDX_W-1:0] REG_CELLS_Z = 3'd5;

	typedef enum logic [1:0] {
		FUNC_ACC     = 2'd0,
		FUNC_READ    = 2'd1,
		FUNC_WRITE   = 2'd2,
		FUNC_RESTART = 2'd3
	} cas_func_t;

	typedef enum logic [1:0] {
		COMP_X = 2'd0,
		COMP_Y = 2'd1,
		COMP_Z = 2'd2
	} cas_comp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DISPATCH,
		ST_ACC,
		ST_READ,
		ST_READ_WAIT,
		ST_FIN
	} cas_state_t;

	typedef struct packed {
		logic       clr_en;
		logic       latch_in;
		logic       rd_acc;
		logic       rd_entry;
		logic [1:0] rd_k;
		logic       wr_acc;
		logic       wr_pre;
		logic       cap_read;
		logic       advance;
		logic       restart;
		logic       load_out;
	} cas_cmd_t;

	typedef struct packed {
		logic      clr_last;
		cas_func_t func;
		logic      comp_ok;
		logic      comp_z;
		logic      in_grid;
	} cas_sts_t;

	// Edge offsets {dz,dy,dx} of the four entries touched by one group.
	function automatic logic [2:0] acc_offset(input cas_comp_t comp, input logic [1:0] k);
		logic [2:0] off;
		off = 3'b000;
		case (comp)
			COMP_X: begin
				case (k)
					2'd1:    off = 3'b010;
					2'd2:    off = 3'b100;
					2'd3:    off = 3'b110;
					default: off = 3'b000;
				endcase
			end
			COMP_Y: begin
				case (k)
					2'd1:    off = 3'b100;
					2'd2:    off = 3'b001;
					2'd3:    off = 3'b101;
					default: off = 3'b000;
				endcase
			end
			COMP_Z: begin
				case (k)
					2'd1:    off = 3'b001;
					2'd2:    off = 3'b010;
					2'd3:    off = 3'b011;
					default: off = 3'b000;
				endcase
			end
			default: off = 3'b000;
		endcase
		return off;
	endfunction

endpackage

// File: src/cas_ram.sv
`timescale 1ns / 1ps

module cas_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/cas_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cas_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  cas_pkg::cas_sts_t sts,
	output cas_pkg::cas_cmd_t cmd
);
	import cas_pkg::*;

	cas_state_t state_q, state_d;
	logic [2:0] k_q, k_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		k_d      = k_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_en = 1'b1;
				if (sts.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.latch_in = 1'b1;
					state_d      = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				k_d     = '0;
				state_d = ST_FIN;
				unique case (sts.func)
					FUNC_ACC: begin
						if (sts.comp_ok) begin
							state_d = ST_ACC;
						end
					end
					FUNC_READ: begin
						if (sts.comp_ok && sts.in_grid) begin
							state_d = ST_READ;
						end
					end
					FUNC_WRITE: begin
						cmd.wr_pre = sts.comp_ok && sts.in_grid;
					end
					FUNC_RESTART: begin
						cmd.restart = 1'b1;
					end
					default: state_d = ST_FIN;
				endcase
			end
			ST_ACC: begin
				// reads at k=0..3, writes at k=1..4, each in the cycle after its read
				cmd.rd_acc = !k_q[2];
				cmd.rd_k   = k_q[1:0];
				cmd.wr_acc = (k_q != 3'd0);
				k_d        = k_q + 3'd1;
				if (k_q[2]) begin
					cmd.advance = sts.comp_z;
					state_d     = ST_FIN;
				end
			end
			ST_READ: begin
				cmd.rd_entry = 1'b1;
				state_d      = ST_READ_WAIT;
			end
			ST_READ_WAIT: begin
				cmd.cap_read = 1'b1;
				state_d      = ST_FIN;
			end
			ST_FIN: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	assign out_valid = out_valid_q;

	`CAS_ASSERT(a_mem_cmd_excl, $onehot0({cmd.clr_en, cmd.wr_pre, cmd.rd_entry, cmd.rd_acc}),
		"conflicting memory commands")
	`CAS_ASSERT(a_accept_dispatch, in_valid && in_ready |=> state_q == ST_DISPATCH,
		"accepted word not dispatched")
	`CAS_ASSERT(a_load_free, cmd.load_out |-> (!out_valid_q || out_ready),
		"result overwrites a pending word")
	`CAS_ASSERT_ALWAYS(a_no_out_in_clear, out_valid_q |-> state_q != ST_CLEAR,
		"result pending during clearing pass")

endmodule

// File: src/cas_dpath.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cas_dpath #(
	parameter int MAX_CELLS_X = cas_pkg::MAX_CELLS_X_DEF,
	parameter int MAX_CELLS_Y = cas_pkg::MAX_CELLS_Y_DEF,
	parameter int MAX_CELLS_Z = cas_pkg::MAX_CELLS_Z_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cas_pkg::cas_cmd_t             cmd,
	output cas_pkg::cas_sts_t             sts,
	input  logic                          cfg_we,
	input  logic [cas_pkg::IDX_W-1:0]     cfg_index,
	input  logic [cas_pkg::DATA_W-1:0]    cfg_data,
	input  logic [1:0]                    func,
	input  logic [1:0]                    component,
	input  logic signed [31:0]            acc0,
	input  logic signed [31:0]            acc1,
	input  logic signed [31:0]            acc2,
	input  logic signed [31:0]            acc3,
	input  logic [3:0]                    cell_x,
	input  logic [3:0]                    cell_y,
	input  logic [3:0]                    cell_z,
	input  logic signed [31:0]            write_value,
	output logic signed [31:0]            read_value,
	output logic                          saturated,
	output logic                          walk_done
);
	import cas_pkg::*;

	localparam int XW    = $clog2(MAX_CELLS_X + 2);
	localparam int YW    = $clog2(MAX_CELLS_Y + 2);
	localparam int ZW    = $clog2(MAX_CELLS_Z + 2);
	localparam int AW    = XW + YW + ZW;
	localparam int DEPTH = 1 << AW;

	// configuration
	logic signed [31:0] scale_x_q, scale_y_q, scale_z_q;
	logic [3:0]         cells_x_q, cells_y_q, cells_z_q;

	// latched word
	cas_func_t          func_q;
	cas_comp_t          comp_q;
	logic signed [31:0] acc_q [4];
	logic [3:0]         cx_q, cy_q, cz_q;
	logic signed [31:0] wv_q;

	// walk
	logic [XW-1:0] vx_q;
	logic [YW-1:0] vy_q;
	logic [ZW-1:0] vz_q;
	logic [XW-1:0] nx;
	logic [YW-1:0] ny;
	logic [ZW-1:0] nz;

	logic [AW-1:0] clr_q;
	logic [AW-1:0] entry_addr, acc_addr, raddr, waddr;
	logic [AW-1:0] waddr_s1;
	logic [2:0]    off;
	logic signed [31:0] wdata, rdata, scale_sel;
	logic signed [31:0] rdata_x, rdata_y, rdata_z;
	logic signed [63:0] prod_s1;
	logic signed [65:0] wide;
	logic signed [49:0] sum;
	logic               ovf;
	logic signed [31:0] sum_sat;
	logic               we_x, we_y, we_z, we_any;

	logic signed [31:0] rd_res_q;
	logic               sat_q, done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q <= SCALE_RESET;
			scale_y_q <= SCALE_RESET;
			scale_z_q <= SCALE_RESET;
			cells_x_q <= CELLS_RESET;
			cells_y_q <= CELLS_RESET;
			cells_z_q <= CELLS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE_X: scale_x_q <= cfg_data;
				REG_SCALE_Y: scale_y_q <= cfg_data;
				REG_SCALE_Z: scale_z_q <= cfg_data;
				REG_CELLS_X: cells_x_q <= cfg_data[3:0];
				REG_CELLS_Y: cells_y_q <= cfg_data[3:0];
				REG_CELLS_Z: cells_z_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			func_q   <= cas_func_t'(func);
			comp_q   <= cas_comp_t'(component);
			acc_q[0] <= acc0;
			acc_q[1] <= acc1;
			acc_q[2] <= acc2;
			acc_q[3] <= acc3;
			cx_q     <= cell_x;
			cy_q     <= cell_y;
			cz_q     <= cell_z;
			wv_q     <= write_value;
		end
	end

	// effective extents: zero counts as one, clamp to the grid
	always_comb begin
		if (cells_x_q == 4'd0)                nx = XW'(1);
		else if (int'(cells_x_q) > MAX_CELLS_X) nx = XW'(MAX_CELLS_X);
		else                                  nx = XW'(cells_x_q);
		if (cells_y_q == 4'd0)                ny = YW'(1);
		else if (int'(cells_y_q) > MAX_CELLS_Y) ny = YW'(MAX_CELLS_Y);
		else                                  ny = YW'(cells_y_q);
		if (cells_z_q == 4'd0)                nz = ZW'(1);
		else if (int'(cells_z_q) > MAX_CELLS_Z) nz = ZW'(MAX_CELLS_Z);
		else                                  nz = ZW'(cells_z_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vx_q  <= XW'(1);
			vy_q  <= YW'(1);
			vz_q  <= ZW'(1);
			clr_q <= '0;
		end else begin
			if (cmd.clr_en) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.restart) begin
				vx_q <= XW'(1);
				vy_q <= YW'(1);
				vz_q <= ZW'(1);
			end else if (cmd.advance) begin
				if (vx_q >= nx) begin
					vx_q <= XW'(1);
					if (vy_q >= ny) begin
						vy_q <= YW'(1);
						if (vz_q >= nz) vz_q <= ZW'(1);
						else            vz_q <= vz_q + ZW'(1);
					end else begin
						vy_q <= vy_q + YW'(1);
					end
				end else begin
					vx_q <= vx_q + XW'(1);
				end
			end
		end
	end

	// addressing
	assign off        = acc_offset(comp_q, cmd.rd_k);
	assign acc_addr   = {vz_q + ZW'(off[2]), vy_q + YW'(off[1]), vx_q + XW'(off[0])};
	assign entry_addr = {ZW'(cz_q), YW'(cy_q), XW'(cx_q)};
	assign raddr      = cmd.rd_entry ? entry_addr : acc_addr;
	assign waddr      = cmd.clr_en ? clr_q : (cmd.wr_pre ? entry_addr : waddr_s1);
	assign wdata      = cmd.clr_en ? '0 : (cmd.wr_pre ? wv_q : sum_sat);

	always_comb begin
		case (comp_q)
			COMP_X:  scale_sel = scale_x_q;
			COMP_Y:  scale_sel = scale_y_q;
			COMP_Z:  scale_sel = scale_z_q;
			default: scale_sel = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.rd_acc) begin
			prod_s1  <= scale_sel * acc_q[cmd.rd_k];
			waddr_s1 <= acc_addr;
		end
	end

	// old + round(prod / 2^16) folded into one add: {old, 0x8000} + prod
	assign wide    = $signed({{18{rdata[31]}}, rdata, 16'h8000}) + $signed({{2{prod_s1[63]}}, prod_s1});
	assign sum     = wide[65:16];
	assign ovf     = !((&sum[49:31]) || !(|sum[49:31]));
	assign sum_sat = !ovf ? sum[31:0] : (sum[49] ? 32'sh8000_0000 : 32'sh7FFF_FFFF);

	assign we_any = cmd.wr_pre || cmd.wr_acc;
	assign we_x   = cmd.clr_en || (we_any && comp_q == COMP_X);
	assign we_y   = cmd.clr_en || (we_any && comp_q == COMP_Y);
	assign we_z   = cmd.clr_en || (we_any && comp_q == COMP_Z);

	cas_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_x (
		.clk(clk), .we(we_x), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata_x)
	);
	cas_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_y (
		.clk(clk), .we(we_y), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata_y)
	);
	cas_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ram_z (
		.clk(clk), .we(we_z), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata_z)
	);

	always_comb begin
		case (comp_q)
			COMP_X:  rdata = rdata_x;
			COMP_Y:  rdata = rdata_y;
			COMP_Z:  rdata = rdata_z;
			default: rdata = '0;
		endcase
	end

	// per-word result
	always_ff @(posedge clk) begin
		if (cmd.latch_in) begin
			rd_res_q <= '0;
			sat_q    <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			if (cmd.cap_read) rd_res_q <= rdata;
			if (cmd.wr_acc && ovf) sat_q <= 1'b1;
			if (cmd.advance && vx_q >= nx && vy_q >= ny && vz_q >= nz) done_q <= 1'b1;
		end
		if (cmd.load_out) begin
			read_value <= rd_res_q;
			saturated  <= sat_q;
			walk_done  <= done_q;
		end
	end

	assign sts.clr_last = &clr_q;
	assign sts.func     = func_q;
	assign sts.comp_ok  = comp_q == COMP_X || comp_q == COMP_Y || comp_q == COMP_Z;
	assign sts.comp_z   = comp_q == COMP_Z;
	assign sts.in_grid  = int'(cx_q) <= MAX_CELLS_X + 1 && int'(cy_q) <= MAX_CELLS_Y + 1
		&& int'(cz_q) <= MAX_CELLS_Z + 1;

	`CAS_ASSERT(a_wr_after_rd, cmd.wr_acc |-> $past(cmd.rd_acc),
		"accumulate write without a preceding read")
	`CAS_ASSERT(a_voxel_nonzero, vx_q != '0 && vy_q != '0 && vz_q != '0,
		"voxel walk left the interior")
	`CAS_ASSERT(a_latch_clears, cmd.latch_in |=> !sat_q && !done_q,
		"result flags not cleared on new word")

endmodule

// File: src/current_accumulator_scatter_add.sv
`timescale 1ns / 1ps
// Channel  | Handshake              | Words
// ---------+------------------------+-------------------------------------------------
// in       | in_valid / in_ready    | func, component, acc0..acc3, cell_x/y/z, write_value
// out      | out_valid / out_ready  | read_value, saturated, walk_done
// cfg      | cfg_we (no wait)       | cfg_index, cfg_data
//
// Accumulate steps each word through accept, dispatch, four read-modify-write
// updates overlapped through one grid memory (read and write ports), and finish.
// Read goes through accept, dispatch, address, wait and finish; write and restart
// through accept, dispatch and finish; one result word per input word. After reset
// a clearing pass zeroes all 2^(AW) entries of each grid (4096 at the default
// extents), with in_ready low; config writes are taken throughout. A stalled
// output holds the finished word; the next word is accepted once the result sits in the output register.

module current_accumulator_scatter_add #(
	parameter int MAX_CELLS_X = cas_pkg::MAX_CELLS_X_DEF,
	parameter int MAX_CELLS_Y = cas_pkg::MAX_CELLS_Y_DEF,
	parameter int MAX_CELLS_Z = cas_pkg::MAX_CELLS_Z_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_we,
	input  logic [cas_pkg::IDX_W-1:0]  cfg_index,
	input  logic [cas_pkg::DATA_W-1:0] cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [1:0]                 func,
	input  logic [1:0]                 component,
	input  logic signed [31:0]         acc0,
	input  logic signed [31:0]         acc1,
	input  logic signed [31:0]         acc2,
	input  logic signed [31:0]         acc3,
	input  logic [3:0]                 cell_x,
	input  logic [3:0]                 cell_y,
	input  logic [3:0]                 cell_z,
	input  logic signed [31:0]         write_value,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic signed [31:0]         read_value,
	output logic                       saturated,
	output logic                       walk_done
);
	import cas_pkg::*;

	cas_cmd_t cmd;
	cas_sts_t sts;

	// sequencing: clear pass, dispatch, update loop, output handoff
	cas_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// grids, scaling multiplier, saturating adder, voxel walk, config
	cas_dpath #(
		.MAX_CELLS_X(MAX_CELLS_X),
		.MAX_CELLS_Y(MAX_CELLS_Y),
		.MAX_CELLS_Z(MAX_CELLS_Z)
	) u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.func       (func),
		.component  (component),
		.acc0       (acc0),
		.acc1       (acc1),
		.acc2       (acc2),
		.acc3       (acc3),
		.cell_x     (cell_x),
		.cell_y     (cell_y),
		.cell_z     (cell_z),
		.write_value(write_value),
		.read_value (read_value),
		.saturated  (saturated),
		.walk_done  (walk_done)
	);

endmodule
